FILE: hw/rtl/go_to_point_heading_controller_defines.svh
// ---------------------------------------------------------------------------
// Go-to-point heading controller: assertion macros
// Checks sampled on clk_i, with and without the reset disable.
// ---------------------------------------------------------------------------
`ifndef GO_TO_POINT_HEADING_CONTROLLER_DEFINES_SVH
`define GO_TO_POINT_HEADING_CONTROLLER_DEFINES_SVH
`ifndef ASSERT_OFF
`define GTPH_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("gtph assertion failed");
`define GTPH_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk_i) prop) else $error("gtph reset check failed");
`else
`define GTPH_ASSERT(name, prop)
`define GTPH_ASSERT_RST(name, prop)
`endif
`endif

FILE: hw/rtl/gtph_pkg.sv
// ---------------------------------------------------------------------------
// gtph_pkg
// Types, constants and tables of the go-to-point heading controller.
// ---------------------------------------------------------------------------
package gtph_pkg;

  localparam int SqrtSteps    = 33;
  localparam int CordicDef    = 16;
  localparam int AtanLen      = 24;
  localparam int NormCells    = 6;

  localparam logic signed [16:0] PiQ13    = 17'sd25736;
  localparam logic signed [16:0] TwoPiQ13 = 17'sd51472;
  localparam logic signed [32:0] HalfPiZ  = 33'sd1686629713;

  localparam logic [15:0] GainRst   = 16'd2048;
  localparam logic [15:0] SpeedRst  = 16'd64;
  localparam logic [31:0] RadiusRst = 32'd6554;

  localparam logic [31:0] AtanTab [AtanLen] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef enum logic [1:0] {
    RegGain   = 2'd0,
    RegSpeed  = 2'd1,
    RegRadius = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
  } gtph_in_t;

  typedef struct packed {
    logic        [15:0] forward_cmd;
    logic signed [15:0] turn_cmd;
    logic        [31:0] range_left;
    logic               arrived;
  } gtph_out_t;

  typedef struct packed {
    logic               sx;
    logic               sy;
    logic signed [15:0] hd;
    logic               arr;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic        [31:0] ax;
    logic        [31:0] ay;
    logic        [63:0] sqx;
    logic        [63:0] sqy;
    logic        [63:0] rsq;
    logic        [65:0] nrm;
    logic        [35:0] rem;
    logic        [32:0] root;
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [32:0] cz;
    logic        [31:0] rng;
    logic signed [16:0] err;
    logic signed [33:0] prod;
  } pipe_t;

  function automatic int norm_shift(int k);
    norm_shift = (k == 0) ? 0 : (16 >> (k - 1));
  endfunction

endpackage

FILE: hw/rtl/go_to_point_heading_controller.sv
// ---------------------------------------------------------------------------
// go_to_point_heading_controller
// Distance and bearing to a goal point, proportional turn command.
//
//   channel  | direction | handshake                 | beat
//   in       | sink      | in_valid_i / in_stall_o   | gtph_in_t
//   out      | source    | out_valid_o / out_stall_i | gtph_out_t
//   cfg      | sink      | APB psel/penable/pready   | 32-bit register
//
// One beat per cycle while the output is not stalled. The pipeline holds the 33-cell
// square root row, the 6 normalize cells and the CORDIC row.
// The whole row advances together; a stalled output beat holds every cell.
// Reset clears all valid bits and loads the register defaults.
// ---------------------------------------------------------------------------
`include "go_to_point_heading_controller_defines.svh"

module go_to_point_heading_controller #(
  parameter int CORDIC_STEPS = gtph_pkg::CordicDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gtph_pkg::gtph_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gtph_pkg::gtph_out_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import gtph_pkg::*;

  localparam int NChain = SqrtSteps + NormCells + CORDIC_STEPS;

  logic [15:0] gain_q;
  logic [15:0] speed_q;
  logic [31:0] radius_q;
  reg_idx_e    ridx;
  logic        adv;

  logic  va_q, vb_q, vc_q, vd_q, ve_q, vq_q, vw_q, vp_q, vo_q;
  pipe_t sa_q, sb_q, sc_q, sd_q, se_q, sq_q, sw_q, sp_q;
  pipe_t sa_d, sb_d, sc_d, sd_d, se_d, sq_d, sw_d, sp_d;
  gtph_out_t out_d, out_q;

  logic  ch_v [NChain+1];
  pipe_t ch_d [NChain+1];

  logic signed [32:0] zc;
  logic        [32:0] zr;
  logic signed [16:0] b0;
  logic signed [16:0] e0;
  logic        [33:0] mag;
  logic        [34:0] rr;
  logic        [16:0] r;

  assign adv        = !(vo_q && out_stall_i);
  assign in_stall_o = !adv;
  assign pready     = 1'b1;
  assign ridx       = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= GainRst;
      speed_q  <= SpeedRst;
      radius_q <= RadiusRst;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        RegGain:   gain_q   <= pwdata[15:0];
        RegSpeed:  speed_q  <= pwdata[15:0];
        RegRadius: radius_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      RegGain:   prdata = {16'd0, gain_q};
      RegSpeed:  prdata = {16'd0, speed_q};
      RegRadius: prdata = radius_q;
      default:   prdata = 32'd0;
    endcase
  end

  always_comb begin
    sa_d    = '0;
    sa_d.dx = 33'(in_data_i.goal_x) - 33'(in_data_i.pos_x);
    sa_d.dy = 33'(in_data_i.goal_y) - 33'(in_data_i.pos_y);
    sa_d.hd = in_data_i.heading;

    sb_d    = sa_q;
    sb_d.sx = sa_q.dx[32];
    sb_d.sy = sa_q.dy[32];
    sb_d.ax = sa_q.dx[32] ? 32'(-sa_q.dx) : sa_q.dx[31:0];
    sb_d.ay = sa_q.dy[32] ? 32'(-sa_q.dy) : sa_q.dy[31:0];
    sb_d.cx = {2'b00, sb_d.ax};
    sb_d.cy = {2'b00, sb_d.ay};
    sb_d.cz = '0;

    sc_d     = sb_q;
    sc_d.sqx = sb_q.ax * sb_q.ax;
    sc_d.sqy = sb_q.ay * sb_q.ay;
    sc_d.rsq = radius_q * radius_q;

    sd_d      = sc_q;
    sd_d.nrm  = {2'b00, sc_q.sqx} + {2'b00, sc_q.sqy};
    sd_d.rem  = '0;
    sd_d.root = '0;

    se_d     = sd_q;
    se_d.arr = sd_q.nrm <= {2'b00, sd_q.rsq};
  end

  assign ch_v[0] = ve_q;
  assign ch_d[0] = se_q;

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    gtph_sqrt_cell u_cell (
      .clk_i, .rst_ni, .adv_i(adv),
      .valid_i(ch_v[k]), .data_i(ch_d[k]),
      .valid_o(ch_v[k+1]), .data_o(ch_d[k+1])
    );
  end

  for (genvar k = 0; k < NormCells; k++) begin : g_norm
    gtph_norm_cell #(.SH(norm_shift(k))) u_cell (
      .clk_i, .rst_ni, .adv_i(adv),
      .valid_i(ch_v[SqrtSteps+k]), .data_i(ch_d[SqrtSteps+k]),
      .valid_o(ch_v[SqrtSteps+k+1]), .data_o(ch_d[SqrtSteps+k+1])
    );
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    gtph_cordic_cell #(.IDX(k)) u_cell (
      .clk_i, .rst_ni, .adv_i(adv),
      .valid_i(ch_v[SqrtSteps+NormCells+k]), .data_i(ch_d[SqrtSteps+NormCells+k]),
      .valid_o(ch_v[SqrtSteps+NormCells+k+1]), .data_o(ch_d[SqrtSteps+NormCells+k+1])
    );
  end

  always_comb begin
    sq_d     = ch_d[NChain];
    sq_d.rng = ch_d[NChain].root[32] ? 32'hFFFF_FFFF : ch_d[NChain].root[31:0];
    if (ch_d[NChain].cz < 0) begin
      zc = '0;
    end else if (ch_d[NChain].cz > HalfPiZ) begin
      zc = HalfPiZ;
    end else begin
      zc = ch_d[NChain].cz;
    end
    zr = {1'b0, zc[31:0]} + 33'd65536;
    b0 = ch_d[NChain].sx ? (PiQ13 - $signed({2'b00, zr[31:17]})) : $signed({2'b00, zr[31:17]});
    sq_d.err = ch_d[NChain].sy ? -b0 : b0;

    sw_d = sq_q;
    e0   = sq_q.err - 17'(sq_q.hd);
    if (e0 > PiQ13) begin
      sw_d.err = e0 - TwoPiQ13;
    end else if (e0 <= -PiQ13) begin
      sw_d.err = e0 + TwoPiQ13;
    end else begin
      sw_d.err = e0;
    end

    sp_d      = sw_q;
    sp_d.prod = $signed({18'd0, gain_q}) * 34'(sw_q.err);

    mag = sp_q.prod[33] ? 34'(-sp_q.prod) : 34'(sp_q.prod);
    rr  = {1'b0, mag} + 35'd65536;
    r   = rr[33:17];
    out_d.range_left = sp_q.rng;
    out_d.arrived    = sp_q.arr;
    if (sp_q.arr) begin
      out_d.forward_cmd = '0;
      out_d.turn_cmd    = '0;
    end else begin
      out_d.forward_cmd = speed_q;
      if (sp_q.prod[33]) begin
        out_d.turn_cmd = (r >= 17'd32768) ? 16'sh8000 : $signed(16'(-r));
      end else begin
        out_d.turn_cmd = (r > 17'd32767) ? 16'sh7FFF : $signed(r[15:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vq_q <= 1'b0;
      vw_q <= 1'b0;
      vp_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
      vq_q <= ch_v[NChain];
      vw_q <= vq_q;
      vp_q <= vw_q;
      vo_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sa_q  <= sa_d;
      sb_q  <= sb_d;
      sc_q  <= sc_d;
      sd_q  <= sd_d;
      se_q  <= se_d;
      sq_q  <= sq_d;
      sw_q  <= sw_d;
      sp_q  <= sp_d;
      out_q <= out_d;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

  `GTPH_ASSERT(a_arrived_zero, out_valid_o && out_data_o.arrived |-> out_data_o.forward_cmd == 16'd0 && out_data_o.turn_cmd == 16'sd0)
  `GTPH_ASSERT(a_cruise, out_valid_o && !out_data_o.arrived |-> out_data_o.forward_cmd == speed_q)
  `GTPH_ASSERT(a_hold_row, vo_q && out_stall_i |=> $stable(out_q) && $stable(vp_q))
  `GTPH_ASSERT_RST(a_reset_empty, !rst_ni |=> !out_valid_o && !va_q)
endmodule

FILE: hw/rtl/gtph_sqrt_cell.sv
// ---------------------------------------------------------------------------
// gtph_sqrt_cell
// One digit of the restoring square root: two radicand bits per cell.
// ---------------------------------------------------------------------------
module gtph_sqrt_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  gtph_pkg::pipe_t data_i,
  output logic           valid_o,
  output gtph_pkg::pipe_t data_o
);
  import gtph_pkg::*;

  logic  [35:0] rem_s;
  logic  [35:0] trial;
  pipe_t        data_d;
  pipe_t        data_q;
  logic         valid_q;

  always_comb begin
    data_d     = data_i;
    rem_s      = {data_i.rem[33:0], data_i.nrm[65:64]};
    trial      = {1'b0, data_i.root, 2'b01};
    data_d.nrm = {data_i.nrm[63:0], 2'b00};
    if (rem_s >= trial) begin
      data_d.rem  = rem_s - trial;
      data_d.root = {data_i.root[31:0], 1'b1};
    end else begin
      data_d.rem  = rem_s;
      data_d.root = {data_i.root[31:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

FILE: hw/rtl/gtph_norm_cell.sv
// ---------------------------------------------------------------------------
// gtph_norm_cell
// One step of the vector normalize: scale x and y so the larger lands in
// [2^30, 2^31). SH of zero is the single right shift.
// ---------------------------------------------------------------------------
module gtph_norm_cell #(
  parameter int SH = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  gtph_pkg::pipe_t data_i,
  output logic           valid_o,
  output gtph_pkg::pipe_t data_o
);
  import gtph_pkg::*;

  logic  [31:0] m;
  pipe_t        data_d;
  pipe_t        data_q;
  logic         valid_q;

  always_comb begin
    data_d = data_i;
    m      = (data_i.cx > data_i.cy) ? data_i.cx[31:0] : data_i.cy[31:0];
    if (SH == 0) begin
      if (m[31]) begin
        data_d.cx = data_i.cx >>> 1;
        data_d.cy = data_i.cy >>> 1;
      end
    end else begin
      if ((m >> (31 - SH)) == 32'd0) begin
        data_d.cx = data_i.cx <<< SH;
        data_d.cy = data_i.cy <<< SH;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

FILE: hw/rtl/gtph_cordic_cell.sv
// ---------------------------------------------------------------------------
// gtph_cordic_cell
// One CORDIC vectoring rotation with its arctangent constant.
// ---------------------------------------------------------------------------
module gtph_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  gtph_pkg::pipe_t data_i,
  output logic           valid_o,
  output gtph_pkg::pipe_t data_o
);
  import gtph_pkg::*;

  localparam logic signed [32:0] Atan = $signed({1'b0, AtanTab[IDX]});

  logic signed [33:0] xs;
  logic signed [33:0] ys;
  pipe_t              data_d;
  pipe_t              data_q;
  logic               valid_q;

  always_comb begin
    data_d = data_i;
    xs     = data_i.cx >>> IDX;
    ys     = data_i.cy >>> IDX;
    if (!data_i.cy[33]) begin
      data_d.cx = data_i.cx + ys;
      data_d.cy = data_i.cy - xs;
      data_d.cz = data_i.cz + Atan;
    end else begin
      data_d.cx = data_i.cx - ys;
      data_d.cy = data_i.cy + xs;
      data_d.cz = data_i.cz - Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule
